>>> rtl/core/rohb_pkg.sv
// rohb_pkg: shared types and constants for the overwriting ring history buffer.
// No dependencies; every other file of the block but rohb_ram refers to it by scoped name.
package rohb_pkg;

	localparam int KIND_W   = 3;
	localparam int OFFSET_W = 8;
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 9;

	// request kind codes as they arrive on the request channel
	localparam logic [KIND_W-1:0] KIND_APPEND      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_READ_AT     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_READ_NEWEST = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ_NEXT   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TRUNCATE    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ZERO_NEXT   = 3'd5;

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_READ_AT,
		OP_READ_NEWEST,
		OP_READ_NEXT,
		OP_TRUNCATE,
		OP_ZERO_NEXT,
		OP_INVALID
	} op_t;

	// decoded command held in the queue between front and back
	typedef struct packed {
		op_t                 op;
		logic [OFFSET_W-1:0] offset;
		logic [WORD_W-1:0]   word;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ
	} back_state_t;

endpackage

>>> rtl/core/rohb_in_if.sv
// rohb_in_if: request channel (valid/ready plus request fields).
// Depends on rohb_pkg for field widths.
interface rohb_in_if;
	logic                           valid;
	logic                           ready;
	logic [rohb_pkg::KIND_W-1:0]    kind;
	logic [rohb_pkg::OFFSET_W-1:0]  offset;
	logic [rohb_pkg::WORD_W-1:0]    write_word;

	modport source (output valid, kind, offset, write_word, input ready);
	modport sink   (input valid, kind, offset, write_word, output ready);
endinterface

>>> rtl/core/rohb_out_if.sv
// rohb_out_if: response channel (valid/ready plus result fields).
// Depends on rohb_pkg for field widths.
interface rohb_out_if;
	logic                          valid;
	logic                          ready;
	logic [rohb_pkg::WORD_W-1:0]   read_word;
	logic [rohb_pkg::COUNT_W-1:0]  stored_count;
	logic                          ring_full;
	logic                          bad_request;

	modport source (output valid, read_word, stored_count, ring_full, bad_request,
		input ready);
	modport sink   (input valid, read_word, stored_count, ring_full, bad_request,
		output ready);
endinterface

>>> rtl/core/overwriting_ring_history_buffer.sv
// overwriting_ring_history_buffer: top level of the history ring.
// Depends on rohb_pkg, rohb_in_if, rohb_out_if, rohb_front, rohb_fifo, rohb_back.
//
// Usage notes:
// - req channel: one transaction per operation (kind, offset, write_word).
//   rsp channel: exactly one transaction per request, in request order.
// - cfg_we/cfg_wdata set the capacity in use (0 reads as 1, clipped to DEPTH)
//   and empty the ring; slot contents stay. Write only while the block is idle.
// - Front decodes kind and pushes into a two-entry command queue; back pops,
//   runs the command against the slot RAM and loads the response register.
// - Path: append, truncate, zero-next and refused requests pass the command queue
//   and then the response register on their way to rsp; reads also pass the
//   RAM's registered read port between the two.
// - Throughput: one command per cycle for writes/pointer ops while rsp.ready
//   is high; for a read the back waits for the RAM read data before it pops again.
// - Reset: pointers and count go to zero, capacity to DEPTH, then the back
//   sweeps the RAM to zero, one slot a cycle, slot 0 up to DEPTH-1; req.ready
//   stays low meanwhile.
// - rsp stall: the response register holds; the back keeps going as long as
//   the response register frees up, the queue absorbs up to two requests more.
module overwriting_ring_history_buffer #(
	parameter int DEPTH      = 256,
	parameter int ITEM_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rohb_pkg::COUNT_W-1:0]  cfg_wdata,
	rohb_in_if.sink                       req,
	rohb_out_if.source                    rsp
);
	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_valid;
	logic           clearing;
	rohb_pkg::cmd_t push_cmd;
	rohb_pkg::cmd_t head_cmd;

	// accept and classify
	rohb_front u_front (
		.req      (req),
		.q_full   (q_full),
		.clearing (clearing),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	// decoupling queue
	rohb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head_cmd  (head_cmd)
	);

	// execute against the ring
	rohb_back #(
		.DEPTH      (DEPTH),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_cmd     (head_cmd),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.rsp       (rsp)
	);

	// no request taken during the clearing sweep
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.ready)
		else $error("request accepted during clearing sweep");

	// back only pops a queue that holds a command
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty command queue");

	// refused requests return a zero word
	a_bad_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.bad_request) |-> (rsp.read_word == '0))
		else $error("refused request with nonzero read word");

	// a full ring is never empty
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ring_full) |-> (rsp.stored_count != '0))
		else $error("ring reported full with zero entries");
endmodule

>>> rtl/core/rohb_ram.sv
// rohb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rohb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/rohb_front.sv
// rohb_front: accepts requests and decodes the kind field into a command.
// Depends on rohb_pkg and rohb_in_if.
module rohb_front (
	rohb_in_if.sink         req,
	input  logic            q_full,
	input  logic            clearing,
	output logic            q_push,
	output rohb_pkg::cmd_t  q_cmd
);
	function automatic rohb_pkg::op_t decode(input logic [rohb_pkg::KIND_W-1:0] k);
		rohb_pkg::op_t o;
		case (k)
			rohb_pkg::KIND_APPEND:      o = rohb_pkg::OP_APPEND;
			rohb_pkg::KIND_READ_AT:     o = rohb_pkg::OP_READ_AT;
			rohb_pkg::KIND_READ_NEWEST: o = rohb_pkg::OP_READ_NEWEST;
			rohb_pkg::KIND_READ_NEXT:   o = rohb_pkg::OP_READ_NEXT;
			rohb_pkg::KIND_TRUNCATE:    o = rohb_pkg::OP_TRUNCATE;
			rohb_pkg::KIND_ZERO_NEXT:   o = rohb_pkg::OP_ZERO_NEXT;
			default:                    o = rohb_pkg::OP_INVALID;
		endcase
		return o;
	endfunction

	assign req.ready     = !q_full && !clearing;
	assign q_push        = req.valid && req.ready;
	assign q_cmd.op      = decode(req.kind);
	assign q_cmd.offset  = req.offset;
	assign q_cmd.word    = req.write_word;
endmodule

>>> rtl/core/rohb_fifo.sv
// rohb_fifo: two-entry command queue decoupling front and back.
// Depends on rohb_pkg.
module rohb_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rohb_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output rohb_pkg::cmd_t  head_cmd
);
	rohb_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head_cmd  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end
endmodule

>>> rtl/core/rohb_back.sv
// rohb_back: executes ring commands against the slot RAM, keeps pointers,
// capacity and the response register. Depends on rohb_pkg, rohb_out_if, rohb_ram.
module rohb_back #(
	parameter int DEPTH      = 256,
	parameter int ITEM_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rohb_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic                          q_valid,
	input  rohb_pkg::cmd_t                q_cmd,
	output logic                          q_pop,
	output logic                          clearing,
	rohb_out_if.source                    rsp
);
	localparam int AW    = $clog2(DEPTH);
	localparam int CAP_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CAP_W > rohb_pkg::COUNT_W) ? CAP_W : rohb_pkg::COUNT_W;
	localparam int XW    = CMP_W + 1;

	rohb_pkg::back_state_t state_q, state_d;
	logic [AW-1:0]    clr_q, clr_d;
	logic [AW-1:0]    oldest_q, oldest_d;
	logic [AW-1:0]    wpos_q, wpos_d;
	logic [CAP_W-1:0] count_q, count_d;
	logic [CAP_W-1:0] cap_q, cap_d;

	logic                         out_valid_q;
	logic [rohb_pkg::WORD_W-1:0]  out_word_q;
	logic [rohb_pkg::COUNT_W-1:0] out_count_q;
	logic                         out_full_q;
	logic                         out_bad_q;

	logic                         out_load;
	logic [rohb_pkg::WORD_W-1:0]  out_word;
	logic                         out_bad;
	logic                         slot_free;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [ITEM_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [ITEM_WIDTH-1:0] ram_rdata;

	logic [XW-1:0] cap_x, count_x, oldest_x, wpos_x, off_x;

	function automatic logic [CAP_W-1:0] clamp_cap(
		input logic [rohb_pkg::COUNT_W-1:0] w);
		logic [CMP_W-1:0] v;
		v = CMP_W'(w);
		if (v == '0) begin
			return CAP_W'(1);
		end
		if (v > CMP_W'(DEPTH)) begin
			return CAP_W'(DEPTH);
		end
		return CAP_W'(v);
	endfunction

	// sum is below twice the capacity, so one conditional subtract wraps it
	function automatic logic [AW-1:0] wrap(input logic [XW-1:0] s,
		input logic [XW-1:0] c);
		logic [XW-1:0] t;
		t = (s >= c) ? (s - c) : s;
		return t[AW-1:0];
	endfunction

	assign cap_x    = XW'(cap_q);
	assign count_x  = XW'(count_q);
	assign oldest_x = XW'(oldest_q);
	assign wpos_x   = XW'(wpos_q);
	assign off_x    = XW'(q_cmd.offset);

	assign slot_free = !out_valid_q || rsp.ready;
	assign clearing  = (state_q == rohb_pkg::ST_CLEAR);

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		oldest_d  = oldest_q;
		wpos_d    = wpos_q;
		count_d   = count_q;
		cap_d     = cap_q;
		ram_we    = 1'b0;
		ram_waddr = wpos_q;
		ram_wdata = '0;
		ram_raddr = wpos_q;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		out_word  = '0;
		out_bad   = 1'b0;

		case (state_q)
			rohb_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				clr_d     = clr_q + AW'(1);
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = rohb_pkg::ST_IDLE;
				end
			end
			rohb_pkg::ST_IDLE: begin
				if (q_valid && slot_free) begin
					q_pop = 1'b1;
					case (q_cmd.op)
						rohb_pkg::OP_APPEND: begin
							if (count_q >= cap_q) begin
								oldest_d = wrap(oldest_x + XW'(1), cap_x);
							end else begin
								count_d = count_q + CAP_W'(1);
							end
							ram_we    = 1'b1;
							ram_wdata = ITEM_WIDTH'(q_cmd.word);
							wpos_d    = wrap(wpos_x + XW'(1), cap_x);
							out_load  = 1'b1;
						end
						rohb_pkg::OP_READ_AT: begin
							if (off_x >= count_x) begin
								out_bad  = 1'b1;
								out_load = 1'b1;
							end else begin
								ram_raddr = wrap(oldest_x + off_x, cap_x);
								state_d   = rohb_pkg::ST_READ;
							end
						end
						rohb_pkg::OP_READ_NEWEST: begin
							if (count_q == '0) begin
								out_bad  = 1'b1;
								out_load = 1'b1;
							end else begin
								ram_raddr = wrap(oldest_x + count_x - XW'(1), cap_x);
								state_d   = rohb_pkg::ST_READ;
							end
						end
						rohb_pkg::OP_READ_NEXT: begin
							state_d = rohb_pkg::ST_READ;
						end
						rohb_pkg::OP_TRUNCATE: begin
							if (off_x >= cap_x) begin
								out_bad = 1'b1;
							end else begin
								count_d = CAP_W'(off_x + XW'(1));
								wpos_d  = wrap(oldest_x + off_x + XW'(1), cap_x);
							end
							out_load = 1'b1;
						end
						rohb_pkg::OP_ZERO_NEXT: begin
							ram_we   = 1'b1;
							out_load = 1'b1;
						end
						default: begin
							out_bad  = 1'b1;
							out_load = 1'b1;
						end
					endcase
				end
			end
			rohb_pkg::ST_READ: begin
				out_load = 1'b1;
				out_word = rohb_pkg::WORD_W'(ram_rdata);
				state_d  = rohb_pkg::ST_IDLE;
			end
			default: begin
				state_d = rohb_pkg::ST_IDLE;
			end
		endcase

		if (cfg_we) begin
			cap_d    = clamp_cap(cfg_wdata);
			oldest_d = '0;
			wpos_d   = '0;
			count_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rohb_pkg::ST_CLEAR;
			clr_q       <= '0;
			oldest_q    <= '0;
			wpos_q      <= '0;
			count_q     <= '0;
			cap_q       <= CAP_W'(DEPTH);
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			oldest_q <= oldest_d;
			wpos_q   <= wpos_d;
			count_q  <= count_d;
			cap_q    <= cap_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q  <= out_word;
			out_count_q <= rohb_pkg::COUNT_W'(count_d);
			out_full_q  <= (count_d == cap_q);
			out_bad_q   <= out_bad;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_word    = out_word_q;
	assign rsp.stored_count = out_count_q;
	assign rsp.ring_full    = out_full_q;
	assign rsp.bad_request  = out_bad_q;

	rohb_ram #(
		.WIDTH (ITEM_WIDTH),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule
